/* hdl/omdg_pkg.sv */
// Shared types and constants for the octant max-dilation grid unit.
package omdg_pkg;

	// Operation codes carried by an input item.
	typedef enum logic {
		OP_MERGE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_HALF_RES = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Z = 2'd3;

	// Width of the octant shift registers.
	localparam int OFS_BITS = 6;

	// Octant sequencing: eight octants per merge.
	localparam int OCT_BITS = 3;
	localparam logic [OCT_BITS-1:0] OCT_LAST = 3'd7;

	// Queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;

	// Configuration register set.
	typedef struct packed {
		logic                half_res;
		logic [OFS_BITS-1:0] off_x;
		logic [OFS_BITS-1:0] off_y;
		logic [OFS_BITS-1:0] off_z;
	} cfg_t;

	// Queue status seen by the producer and the consumer.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

/* hdl/octant_max_dilation_grid_unit.sv */
// Top level of the octant max-dilation grid unit.
//
// Channel   Direction  Transfer condition      Payload
// item      in         start && !busy          operation, coord_x/y/z, cell_in
// result    out        done (one cycle)        cell_out
// config    in         cfg_wr_en               cfg_index, cfg_wdata
//
// A merge occupies the front for one grid update per octant, limited by the
// single write port of the grid memory; a read occupies it for a single update.
// A read result is registered in the front, the queue, the read stage and cell_out.
// After reset the grid memory is cleared one cell per cycle, and busy stays high
// during the clearing pass.
// The back part stalls only while clearing; the receiver of results cannot stall.
module octant_max_dilation_grid_unit #(
	parameter int AXIS_BITS = 6,
	parameter int CELL_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic signed [AXIS_BITS-1:0]       coord_x,
	input  logic signed [AXIS_BITS-1:0]       coord_y,
	input  logic signed [AXIS_BITS-1:0]       coord_z,
	input  logic [CELL_BITS-1:0]              cell_in,
	output logic                              done,
	output logic [CELL_BITS-1:0]              cell_out,
	input  logic                              cfg_wr_en,
	input  logic [omdg_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [omdg_pkg::OFS_BITS-1:0]     cfg_wdata
);

	localparam int ENTRY_W = 2 + 3 * AXIS_BITS + CELL_BITS;

	omdg_pkg::qstat_t     qstat;
	logic                 push;
	logic                 pop;
	logic                 clear_busy;
	logic [ENTRY_W-1:0]   push_data;
	logic [ENTRY_W-1:0]   head;

	// Item intake and octant sequencing.
	omdg_front #(
		.AXIS_BITS(AXIS_BITS),
		.CELL_BITS(CELL_BITS),
		.ENTRY_W  (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.coord_z   (coord_z),
		.cell_in   (cell_in),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.clear_busy(clear_busy),
		.qstat     (qstat),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	// Update queue.
	omdg_queue #(
		.ENTRY_W(ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// Grid memory and update pipeline.
	omdg_back #(
		.AXIS_BITS(AXIS_BITS),
		.CELL_BITS(CELL_BITS),
		.ENTRY_W  (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.clear_busy(clear_busy),
		.done      (done),
		.cell_out  (cell_out)
	);

endmodule

/* hdl/omdg_front.sv */
// Front part: accepts items, holds settings, emits one update per octant or read.
module omdg_front #(
	parameter int AXIS_BITS = 6,
	parameter int CELL_BITS = 8,
	parameter int ENTRY_W   = 2 + 3 * AXIS_BITS + CELL_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              operation,
	input  logic signed [AXIS_BITS-1:0]       coord_x,
	input  logic signed [AXIS_BITS-1:0]       coord_y,
	input  logic signed [AXIS_BITS-1:0]       coord_z,
	input  logic [CELL_BITS-1:0]              cell_in,
	input  logic                              cfg_wr_en,
	input  logic [omdg_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [omdg_pkg::OFS_BITS-1:0]     cfg_wdata,
	input  logic                              clear_busy,
	input  omdg_pkg::qstat_t                  qstat,
	output logic                              busy,
	output logic                              push,
	output logic [ENTRY_W-1:0]                push_data
);

	// Working width for a coordinate after the shift is subtracted.
	localparam int DW = ((AXIS_BITS > omdg_pkg::OFS_BITS) ? AXIS_BITS : omdg_pkg::OFS_BITS) + 2;

	omdg_pkg::cfg_t                  cfg_q;
	logic                            gen_q;
	logic [omdg_pkg::OCT_BITS-1:0]   oct_q;
	omdg_pkg::op_t                   op_q;
	logic [AXIS_BITS-1:0]            cx_q;
	logic [AXIS_BITS-1:0]            cy_q;
	logic [AXIS_BITS-1:0]            cz_q;
	logic [CELL_BITS-1:0]            val_q;

	logic                            accept;
	logic                            last;
	logic [AXIS_BITS:0]              tx;
	logic [AXIS_BITS:0]              ty;
	logic [AXIS_BITS:0]              tz;

	// Target along one axis: returns {in_grid, grid index}.
	function automatic logic [AXIS_BITS:0] axis_target(
		input logic [AXIS_BITS-1:0]          c,
		input logic [omdg_pkg::OFS_BITS-1:0] off,
		input logic                          sub,
		input logic                          half
	);
		logic [DW-1:0]          t;
		logic [DW-AXIS_BITS:0]  hi;
		logic                   ok;
		t = {{(DW - AXIS_BITS){c[AXIS_BITS-1]}}, c};
		if (sub) begin
			t = t - {{(DW - omdg_pkg::OFS_BITS){1'b0}}, off};
		end
		if (half) begin
			t = {t[DW-1], t[DW-1:1]};
		end
		hi = t[DW-1:AXIS_BITS-1];
		ok = (hi == '0) || (hi == '1);
		return {ok, ~t[AXIS_BITS-1], t[AXIS_BITS-2:0]};
	endfunction

	assign accept = start && !busy;
	assign push   = gen_q && !qstat.full;
	assign last   = (op_q == omdg_pkg::OP_READ) || (oct_q == omdg_pkg::OCT_LAST);
	assign busy   = clear_busy || (gen_q && !(push && last));

	// Octant targets; a read addresses the stored grid directly.
	always_comb begin
		if (op_q == omdg_pkg::OP_READ) begin
			tx = axis_target(cx_q, cfg_q.off_x, 1'b0, 1'b0);
			ty = axis_target(cy_q, cfg_q.off_y, 1'b0, 1'b0);
			tz = axis_target(cz_q, cfg_q.off_z, 1'b0, 1'b0);
		end else begin
			tx = axis_target(cx_q, cfg_q.off_x, oct_q[0], cfg_q.half_res);
			ty = axis_target(cy_q, cfg_q.off_y, oct_q[1], cfg_q.half_res);
			tz = axis_target(cz_q, cfg_q.off_z, oct_q[2], cfg_q.half_res);
		end
		push_data = {op_q == omdg_pkg::OP_READ,
			tx[AXIS_BITS] && ty[AXIS_BITS] && tz[AXIS_BITS],
			tz[AXIS_BITS-1:0], ty[AXIS_BITS-1:0], tx[AXIS_BITS-1:0], val_q};
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_res <= 1'b0;
			cfg_q.off_x    <= omdg_pkg::OFS_BITS'(1);
			cfg_q.off_y    <= omdg_pkg::OFS_BITS'(1);
			cfg_q.off_z    <= omdg_pkg::OFS_BITS'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				omdg_pkg::REG_HALF_RES: cfg_q.half_res <= cfg_wdata[0];
				omdg_pkg::REG_OFFSET_X: cfg_q.off_x    <= cfg_wdata;
				omdg_pkg::REG_OFFSET_Y: cfg_q.off_y    <= cfg_wdata;
				omdg_pkg::REG_OFFSET_Z: cfg_q.off_z    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Octant sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= 1'b0;
			oct_q <= '0;
		end else if (accept) begin
			gen_q <= 1'b1;
			oct_q <= '0;
		end else if (push && last) begin
			gen_q <= 1'b0;
		end else if (push) begin
			oct_q <= oct_q + 1'b1;
		end
	end

	// Item payload captured on transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= omdg_pkg::op_t'(operation);
			cx_q  <= coord_x;
			cy_q  <= coord_y;
			cz_q  <= coord_z;
			val_q <= cell_in;
		end
	end

endmodule

/* hdl/omdg_queue.sv */
// Short queue of grid updates between the front and back parts.
module omdg_queue #(
	parameter int ENTRY_W = 28
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [ENTRY_W-1:0] push_data,
	input  logic               pop,
	output logic [ENTRY_W-1:0] head,
	output omdg_pkg::qstat_t   qstat
);

	logic [ENTRY_W-1:0]           slot_q [omdg_pkg::QUEUE_DEPTH];
	logic [omdg_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [omdg_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [omdg_pkg::QPTR_BITS:0]   count_q;

	assign head        = slot_q[rd_ptr_q];
	assign qstat.full  = (count_q == (omdg_pkg::QPTR_BITS + 1)'(omdg_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/omdg_back.sv */
// Back part: grid memory, clearing pass and read-modify-write max update.
module omdg_back #(
	parameter int AXIS_BITS = 6,
	parameter int CELL_BITS = 8,
	parameter int ENTRY_W   = 2 + 3 * AXIS_BITS + CELL_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  omdg_pkg::qstat_t     qstat,
	input  logic [ENTRY_W-1:0]   head,
	output logic                 pop,
	output logic                 clear_busy,
	output logic                 done,
	output logic [CELL_BITS-1:0] cell_out
);

	localparam int ADDR_W     = 3 * AXIS_BITS;
	localparam int GRID_CELLS = 1 << ADDR_W;

	logic [CELL_BITS-1:0] grid_mem [GRID_CELLS];

	logic                 clear_q;
	logic [ADDR_W-1:0]    clr_addr_q;

	logic                 vld_s1;
	logic                 rd_s1;
	logic                 ok_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [CELL_BITS-1:0] val_s1;
	logic [CELL_BITS-1:0] rdata_s1;

	logic                 wr_vld_q;
	logic [ADDR_W-1:0]    wr_addr_q;
	logic [CELL_BITS-1:0] wr_data_q;

	logic                 done_q;
	logic [CELL_BITS-1:0] cell_out_q;

	logic [ADDR_W-1:0]    head_addr;
	logic [CELL_BITS-1:0] old_val;
	logic [CELL_BITS-1:0] new_val;
	logic                 upd_we;
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [CELL_BITS-1:0] mem_wdata;

	assign head_addr  = head[CELL_BITS +: ADDR_W];
	assign pop        = !qstat.empty && !clear_q;
	assign clear_busy = clear_q;
	assign done       = done_q;
	assign cell_out   = cell_out_q;

	// The cell written last cycle is not yet visible in the read data.
	assign old_val = (wr_vld_q && (wr_addr_q == addr_s1)) ? wr_data_q : rdata_s1;
	assign new_val = (val_s1 > old_val) ? val_s1 : old_val;
	assign upd_we  = vld_s1 && !rd_s1 && ok_s1;

	// Write port shared by the clearing pass and the max update.
	always_comb begin
		if (clear_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = upd_we;
			mem_waddr = addr_s1;
			mem_wdata = new_val;
		end
	end

	// Grid memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= grid_mem[head_addr];
	end

	// Clearing pass after reset, one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clear_q <= 1'b0;
			end
		end
	end

	// Pipeline control, forwarding valid and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			wr_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			vld_s1   <= pop;
			wr_vld_q <= upd_we && !clear_q;
			done_q   <= vld_s1 && rd_s1;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		rd_s1      <= head[ENTRY_W-1];
		ok_s1      <= head[ENTRY_W-2];
		addr_s1    <= head_addr;
		val_s1     <= head[CELL_BITS-1:0];
		wr_addr_q  <= addr_s1;
		wr_data_q  <= new_val;
		cell_out_q <= ok_s1 ? old_val : '0;
	end

endmodule

/* hdl/omdg_checker.sv */
// Port-level assertions for the octant max-dilation grid unit, with its bind.
module omdg_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic operation,
	input logic done
);

	// A read transfer always produces its result strobe.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == omdg_pkg::OP_READ)) |-> ##4 done)
		else $error("read result missing four cycles after transfer");

	// Every result strobe traces back to an earlier read transfer.
	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (operation == omdg_pkg::OP_READ), 4))
		else $error("result strobe without a matching read transfer");

	// A merge keeps the unit busy while its octants are sequenced.
	a_merge_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == omdg_pkg::OP_MERGE)) |=> busy)
		else $error("unit not busy after a merge transfer");

endmodule

bind octant_max_dilation_grid_unit omdg_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.operation(operation),
	.done     (done)
);

/* tb/octant_max_dilation_grid_unit_test.sv */
// Self-checking testbench for the octant max-dilation grid unit.
`timescale 1ns / 100ps

module octant_max_dilation_grid_unit_test;

	localparam int AXIS_BITS   = 6;
	localparam int CELL_BITS   = 8;
	localparam int AXIS_HALF   = 1 << (AXIS_BITS - 1);
	localparam int GRID_CELLS  = 1 << (3 * AXIS_BITS);
	// A merge holds the front while its octants are sent, and a read result trails.
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_GAP       = 24;
	localparam int TOUCHED_KEEP  = 256;
	localparam int PHASE_ITEMS   = 165;
	localparam int NUM_PHASES    = 8;

	typedef enum bit {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t                         kind;
		omdg_pkg::op_t                     op;
		int                                x;
		int                                y;
		int                                z;
		int                                val;
		bit                                has_want;
		int                                want;
		logic [omdg_pkg::CFG_IDX_BITS-1:0] reg_idx;
		int                                wdata;
	} stim_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic                              operation;
	logic signed [AXIS_BITS-1:0]       coord_x;
	logic signed [AXIS_BITS-1:0]       coord_y;
	logic signed [AXIS_BITS-1:0]       coord_z;
	logic [CELL_BITS-1:0]              cell_in;
	logic                              done;
	logic [CELL_BITS-1:0]              cell_out;
	logic                              cfg_wr_en;
	logic [omdg_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [omdg_pkg::OFS_BITS-1:0]     cfg_wdata;

	// Shadow copy of the grid and of the register set.
	logic [CELL_BITS-1:0] grid_shadow [0:GRID_CELLS-1];
	omdg_pkg::cfg_t       cfg_shadow;

	logic [CELL_BITS-1:0] pending_cells [$];
	int                   touched_cells [$];
	stim_row_t            directed_rows [$];
	logic [CELL_BITS-1:0] want_cell;

	int errors;
	int merges_sent;
	int reads_sent;
	int results_checked;
	int settings_applied;

	octant_max_dilation_grid_unit #(
		.AXIS_BITS(AXIS_BITS),
		.CELL_BITS(CELL_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.cell_in(cell_in),
		.done(done),
		.cell_out(cell_out),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Flat grid address of a coordinate, or -1 when it lies outside the grid.
	function automatic int grid_addr(int x, int y, int z);
		if (x < -AXIS_HALF || x >= AXIS_HALF || y < -AXIS_HALF || y >= AXIS_HALF ||
				z < -AXIS_HALF || z >= AXIS_HALF) begin
			return -1;
		end
		return ((z + AXIS_HALF) << (2 * AXIS_BITS)) | ((y + AXIS_HALF) << AXIS_BITS) |
			(x + AXIS_HALF);
	endfunction

	// Spread one source cell over its eight octant targets by taking the maximum.
	function automatic void dilate_shadow(int x, int y, int z, logic [CELL_BITS-1:0] val);
		int tx;
		int ty;
		int tz;
		int idx;
		for (int k = 0; k < 8; k++) begin
			tx = x - (((k & 1) != 0) ? int'(cfg_shadow.off_x) : 0);
			ty = y - (((k & 2) != 0) ? int'(cfg_shadow.off_y) : 0);
			tz = z - (((k & 4) != 0) ? int'(cfg_shadow.off_z) : 0);
			// Halving rounds toward minus infinity.
			if (cfg_shadow.half_res) begin
				tx = tx >>> 1;
				ty = ty >>> 1;
				tz = tz >>> 1;
			end
			idx = grid_addr(tx, ty, tz);
			if (idx >= 0) begin
				if (grid_shadow[idx] < val) begin
					grid_shadow[idx] = val;
				end
				touched_cells.push_back(idx);
				if (touched_cells.size() > TOUCHED_KEEP) begin
					void'(touched_cells.pop_front());
				end
			end
		end
	endfunction

	function automatic stim_row_t item_row(omdg_pkg::op_t op, int x, int y, int z, int val,
			bit has_want = 1'b0, int want = 0);
		stim_row_t r;
		r.kind     = ROW_ITEM;
		r.op       = op;
		r.x        = x;
		r.y        = y;
		r.z        = z;
		r.val      = val;
		r.has_want = has_want;
		r.want     = want;
		r.reg_idx  = omdg_pkg::REG_HALF_RES;
		r.wdata    = 0;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [omdg_pkg::CFG_IDX_BITS-1:0] reg_idx,
			int wdata);
		stim_row_t r;
		r = item_row(omdg_pkg::OP_MERGE, 0, 0, 0, 0);
		r.kind    = ROW_CFG;
		r.reg_idx = reg_idx;
		r.wdata   = wdata;
		return r;
	endfunction

	// Present one item, wait for its transfer, then update the shadow state.
	task automatic send_item(omdg_pkg::op_t op, int x, int y, int z, int val,
			bit has_want = 1'b0, int want = 0);
		logic signed [AXIS_BITS-1:0] cx;
		logic signed [AXIS_BITS-1:0] cy;
		logic signed [AXIS_BITS-1:0] cz;
		cx = x[AXIS_BITS-1:0];
		cy = y[AXIS_BITS-1:0];
		cz = z[AXIS_BITS-1:0];
		start     <= 1'b1;
		operation <= op;
		coord_x   <= cx;
		coord_y   <= cy;
		coord_z   <= cz;
		cell_in   <= val[CELL_BITS-1:0];
		do begin
			@(posedge clk);
		end while (busy);
		if (op == omdg_pkg::OP_READ) begin
			if (has_want) begin
				pending_cells.push_back(want[CELL_BITS-1:0]);
			end else begin
				pending_cells.push_back(grid_shadow[grid_addr(int'(cx), int'(cy), int'(cz))]);
			end
			reads_sent++;
		end else begin
			dilate_shadow(int'(cx), int'(cy), int'(cz), val[CELL_BITS-1:0]);
			merges_sent++;
		end
	endtask

	// Sender gap: idle cycles drawn with the given per-cycle chance.
	task automatic sender_gap(int idle_pct);
		int n;
		n = 0;
		while (n < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			n++;
		end
	endtask

	// Stop sending until every read result is back and the block has gone quiet.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_cells.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	// One register write; the enable is lowered by the caller after a batch.
	task automatic write_reg(logic [omdg_pkg::CFG_IDX_BITS-1:0] reg_idx, int wdata);
		cfg_wr_en <= 1'b1;
		cfg_index <= reg_idx;
		cfg_wdata <= wdata[omdg_pkg::OFS_BITS-1:0];
		@(posedge clk);
		case (reg_idx)
			omdg_pkg::REG_HALF_RES: cfg_shadow.half_res = wdata[0];
			omdg_pkg::REG_OFFSET_X: cfg_shadow.off_x    = wdata[omdg_pkg::OFS_BITS-1:0];
			omdg_pkg::REG_OFFSET_Y: cfg_shadow.off_y    = wdata[omdg_pkg::OFS_BITS-1:0];
			omdg_pkg::REG_OFFSET_Z: cfg_shadow.off_z    = wdata[omdg_pkg::OFS_BITS-1:0];
			default: ;
		endcase
	endtask

	// Load a full register setting while the block is idle.
	task automatic apply_setting(bit half, int ox, int oy, int oz);
		drain_results();
		// Bits above the mode flag are junk that the block must ignore.
		write_reg(omdg_pkg::REG_HALF_RES, {26'd0, 5'($urandom_range(0, 31)), half});
		write_reg(omdg_pkg::REG_OFFSET_X, ox);
		write_reg(omdg_pkg::REG_OFFSET_Y, oy);
		write_reg(omdg_pkg::REG_OFFSET_Z, oz);
		cfg_wr_en <= 1'b0;
		settings_applied++;
	endtask

	// Random item: half of the merges land in a small cube so that maxima interact,
	// and reads mostly revisit cells that merges have touched.
	task automatic random_item();
		int x;
		int y;
		int z;
		int idx;
		if ($urandom_range(0, 99) < 55) begin
			if ($urandom_range(0, 1) == 0) begin
				x = int'($urandom_range(0, 7)) - 4;
				y = int'($urandom_range(0, 7)) - 4;
				z = int'($urandom_range(0, 7)) - 4;
			end else begin
				x = int'($urandom_range(0, 63)) - AXIS_HALF;
				y = int'($urandom_range(0, 63)) - AXIS_HALF;
				z = int'($urandom_range(0, 63)) - AXIS_HALF;
			end
			send_item(omdg_pkg::OP_MERGE, x, y, z, $urandom_range(0, 255));
		end else begin
			if (touched_cells.size() != 0 && $urandom_range(0, 99) < 70) begin
				idx = touched_cells[$urandom_range(0, touched_cells.size() - 1)];
				x = (idx & 63) - AXIS_HALF;
				y = ((idx >> AXIS_BITS) & 63) - AXIS_HALF;
				z = ((idx >> (2 * AXIS_BITS)) & 63) - AXIS_HALF;
			end else begin
				x = int'($urandom_range(0, 63)) - AXIS_HALF;
				y = int'($urandom_range(0, 63)) - AXIS_HALF;
				z = int'($urandom_range(0, 63)) - AXIS_HALF;
			end
			send_item(omdg_pkg::OP_READ, x, y, z, $urandom_range(0, 255));
		end
	endtask

	// Result checker: every strobe must match the oldest pending read.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_cells.size() == 0) begin
				errors++;
				$display("%0t: result with no read pending, expected none, actual cell_out=%0d",
					$time, cell_out);
			end else begin
				want_cell = pending_cells.pop_front();
				results_checked++;
				if (cell_out !== want_cell) begin
					errors++;
					$display("%0t: cell_out mismatch, expected %0d, actual %0d",
						$time, want_cell, cell_out);
				end
			end
		end
	end

	// Run limit, sized for the clearing pass plus a slow run several times over.
	initial begin
		#20_000_000;
		$display("Timeout with %0d results outstanding", pending_cells.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// Main stimulus.
	initial begin
		bit in_cfg;
		int idle_pct;
		errors           = 0;
		merges_sent      = 0;
		reads_sent       = 0;
		results_checked  = 0;
		settings_applied = 0;
		for (int i = 0; i < GRID_CELLS; i++) begin
			grid_shadow[i] = '0;
		end
		cfg_shadow = '{half_res: 1'b0, off_x: 6'd1, off_y: 6'd1, off_z: 6'd1};

		arst_n    = 1'b0;
		start     <= 1'b0;
		operation <= omdg_pkg::OP_MERGE;
		coord_x   <= '0;
		coord_y   <= '0;
		coord_z   <= '0;
		cell_in   <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= omdg_pkg::REG_HALF_RES;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// The grid is cleared after reset while busy is high.
		while (busy) begin
			@(posedge clk);
		end

		// Directed part: reset values, grid corners, maxima, then mode changes.
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, 0, 0, 0, 0, 1'b1, 0));
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, -32, -32, -32, 255, 1'b1, 0));
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, 31, 31, 31, 0, 1'b1, 0));
		// At the low corner only the unshifted octant stays inside the grid.
		directed_rows.push_back(item_row(omdg_pkg::OP_MERGE, -32, -32, -32, 255));
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, -32, -32, -32, 0, 1'b1, 255));
		directed_rows.push_back(item_row(omdg_pkg::OP_MERGE, 31, 31, 31, 200));
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, 30, 30, 30, 0, 1'b1, 200));
		directed_rows.push_back(item_row(omdg_pkg::OP_MERGE, 31, 31, 31, 100));
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, 31, 30, 31, 0, 1'b1, 200));
		directed_rows.push_back(item_row(omdg_pkg::OP_MERGE, 0, 0, 0, 0));
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, -1, -1, -1, 0, 1'b1, 0));
		directed_rows.push_back(cfg_row(omdg_pkg::REG_HALF_RES, 63));
		directed_rows.push_back(cfg_row(omdg_pkg::REG_OFFSET_X, 0));
		directed_rows.push_back(cfg_row(omdg_pkg::REG_OFFSET_Y, 63));
		directed_rows.push_back(cfg_row(omdg_pkg::REG_OFFSET_Z, 2));
		// Half resolution: negative targets round down, reads are not halved.
		directed_rows.push_back(item_row(omdg_pkg::OP_MERGE, -1, -32, 5, 77));
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, -1, -16, 2, 0));
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, -1, -16, 1, 0));
		directed_rows.push_back(item_row(omdg_pkg::OP_MERGE, 31, 31, 31, 9));
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, 15, 15, 15, 0));
		directed_rows.push_back(cfg_row(omdg_pkg::REG_HALF_RES, 0));
		directed_rows.push_back(cfg_row(omdg_pkg::REG_OFFSET_X, 63));
		directed_rows.push_back(cfg_row(omdg_pkg::REG_OFFSET_Y, 63));
		directed_rows.push_back(cfg_row(omdg_pkg::REG_OFFSET_Z, 63));
		// Full offsets move the top corner onto the bottom corner.
		directed_rows.push_back(item_row(omdg_pkg::OP_MERGE, 31, 31, 31, 250));
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, -32, -32, -32, 0));
		directed_rows.push_back(item_row(omdg_pkg::OP_READ, -32, 31, -32, 0));

		in_cfg = 1'b0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				if (!in_cfg) begin
					drain_results();
					in_cfg = 1'b1;
				end
				write_reg(directed_rows[i].reg_idx, directed_rows[i].wdata);
			end else begin
				if (in_cfg) begin
					cfg_wr_en <= 1'b0;
					in_cfg = 1'b0;
					settings_applied++;
				end
				send_item(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
					directed_rows[i].z, directed_rows[i].val, directed_rows[i].has_want,
					directed_rows[i].want);
			end
		end

		// Random part: one register setting per phase, extremes first.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: apply_setting(1'b0, 1, 1, 1);
				1: apply_setting(1'b1, 0, 0, 0);
				2: apply_setting(1'b0, 63, 63, 63);
				3: apply_setting(1'b1, 63, 63, 63);
				4: apply_setting(1'b0, 0, 0, 0);
				default: apply_setting(1'($urandom_range(0, 1)), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 63));
			endcase
			case (phase % 4)
				1: idle_pct = 85;
				3: idle_pct = 29;
				default: idle_pct = 0;
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Once, the sender holds off until every result is back.
				if (phase == 1 && n == PHASE_ITEMS / 2) begin
					drain_results();
				end
				sender_gap(idle_pct);
				random_item();
			end
		end

		// Wind down: wait for the last results, then let the block settle.
		start <= 1'b0;
		@(posedge clk);
		while (pending_cells.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_cells.size() != 0) begin
			errors++;
			$display("%0t: %0d reads never returned a result", $time, pending_cells.size());
		end

		$display("Covered %0d merges and %0d reads across %0d register settings;",
			merges_sent, reads_sent, settings_applied);
		$display("%0d read results compared, %0d mismatches.", results_checked, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
